>>> sv/assert_macros.svh
// assertion macros shared by the deframer rtl
// no dependencies; the checks are left out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_AT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed: %m");
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition: %m");
`else
`define ASSERT_AT(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

>>> sv/trd_pkg.sv
// types, constants and register codes of the tunnel record deframer
// used by every module of the block; no dependencies
package trd_pkg;

   localparam int HEADER_BYTES = 8;
   localparam int POS_W        = 17;
   localparam int LEN_W        = 16;
   localparam int CNT_W        = POS_W + 1;

   localparam logic [POS_W-1:0] POS_MAX = '1;

   localparam logic [7:0] MAGIC_S     = 8'h53;
   localparam logic [7:0] MAGIC_T     = 8'h54;
   localparam logic [7:0] MAGIC_F     = 8'h46;
   localparam logic [7:0] HDR_VERSION = 8'h01;
   localparam logic [7:0] HDR_PAD     = 8'h00;

   // byte offsets inside the reliable header
   localparam logic [2:0] HDR_POS_S      = 3'd0;
   localparam logic [2:0] HDR_POS_T      = 3'd1;
   localparam logic [2:0] HDR_POS_F      = 3'd2;
   localparam logic [2:0] HDR_POS_VER    = 3'd3;
   localparam logic [2:0] HDR_POS_LEN_HI = 3'd4;
   localparam logic [2:0] HDR_POS_LEN_LO = 3'd5;
   localparam logic [2:0] HDR_POS_TYPE   = 3'd6;

   // register index, taken from paddr bit 2
   localparam logic REG_DATA_TYPE  = 1'b0;
   localparam logic REG_PROBE_TYPE = 1'b1;

   localparam logic [7:0] DATA_TYPE_RESET  = 8'd0;
   localparam logic [7:0] PROBE_TYPE_RESET = 8'd3;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_TOO_SHORT  = 2'd1,
      STATUS_BAD_HEADER = 2'd2,
      STATUS_LEN_MISM   = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0] data_type_code;
      logic [7:0] probe_type_code;
   } cfg_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       is_datagram;
      logic       end_of_record;
   } item_type;

   typedef struct packed {
      logic       payload_valid;
      logic [7:0] forward_byte;
      logic       record_done;
      status_type status;
      logic [7:0] packet_type;
      logic       send_probe_reply;
      logic       reply_on_datagram;
   } result_type;

endpackage

>>> sv/tunnel_record_deframer_unit.sv
// tunnel record deframer: input word register, parser and result register
// depends on trd_pkg, trd_csr, trd_parse and assert_macros.svh
//
// usage: the req channel takes one record byte per word with its channel bit
// (reliable with an 8-byte header, or datagram with a 1-byte type) and an
// end-of-record mark on the last byte. the rsp channel returns a word for
// every forwarded payload byte of a data-type record and one for the last
// byte, which carries status, type and the probe reply flags. other bytes
// give no rsp word. payload is forwarded before the record is checked, so the
// receiver drops it when the final status is not ok.
// an accepted word goes from the input register through the parser into the
// result register, which drives rsp.
// throughput: one word per cycle while no rsp stall holds the input register,
// set by the parser step between the input register and the result register.
// when the receiver stalls, the result register holds its word and the input
// register takes one more; req_ready falls only when both are full.
// reset (synchronous) empties both registers, clears the record state and
// loads the type codes with their defaults; there is no clearing pass.
// the user must write the csr port only while the block is idle; the block does not enforce it.
`include "assert_macros.svh"
module tunnel_record_deframer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_is_datagram,
   input  logic        req_end_of_record,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_payload_valid,
   output logic [7:0]  rsp_forward_byte,
   output logic        rsp_record_done,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_packet_type,
   output logic        rsp_send_probe_reply,
   output logic        rsp_reply_on_datagram,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   trd_pkg::cfg_type    cfg;
   trd_pkg::item_type   item_ff;
   trd_pkg::result_type res;
   trd_pkg::result_type out_ff;
   logic                in_valid_ff;
   logic                out_valid_ff;
   logic                res_emit;
   logic                out_free;
   logic                advance;

   trd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   trd_parse u_parse (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .item     (item_ff),
      .advance  (advance),
      .res      (res),
      .res_emit (res_emit)
   );

   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && (!res_emit || out_free);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff.data_byte     <= req_data_byte;
         item_ff.is_datagram   <= req_is_datagram;
         item_ff.end_of_record <= req_end_of_record;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && res_emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res_emit) begin
         out_ff <= res;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_payload_valid     = out_ff.payload_valid;
   assign rsp_forward_byte      = out_ff.forward_byte;
   assign rsp_record_done       = out_ff.record_done;
   assign rsp_status            = out_ff.status;
   assign rsp_packet_type       = out_ff.packet_type;
   assign rsp_send_probe_reply  = out_ff.send_probe_reply;
   assign rsp_reply_on_datagram = out_ff.reply_on_datagram;

   `ASSERT_AT(a_accept_loads, clock, reset,
      (req_valid && req_ready) |=> in_valid_ff)
   `ASSERT_NEVER(a_no_empty_word, clock, reset,
      rsp_valid && !rsp_payload_valid && !rsp_record_done)
   `ASSERT_AT(a_stall_blocks, clock, reset,
      (in_valid_ff && res_emit && out_valid_ff && !rsp_ready) |-> !advance)

endmodule

>>> sv/trd_csr.sv
// configuration registers of the deframer on an apb-style port
// depends on trd_pkg
module trd_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [2:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready,
   output trd_pkg::cfg_type cfg
);

   logic [7:0] data_code_ff;
   logic [7:0] probe_code_ff;
   logic       wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         data_code_ff  <= trd_pkg::DATA_TYPE_RESET;
         probe_code_ff <= trd_pkg::PROBE_TYPE_RESET;
      end else if (wr_en) begin
         if (csr_paddr[2] == trd_pkg::REG_DATA_TYPE) begin
            data_code_ff <= csr_pwdata[7:0];
         end else begin
            probe_code_ff <= csr_pwdata[7:0];
         end
      end
   end

   always_comb begin
      if (csr_paddr[2] == trd_pkg::REG_DATA_TYPE) begin
         csr_prdata = {24'd0, data_code_ff};
      end else begin
         csr_prdata = {24'd0, probe_code_ff};
      end
   end

   assign cfg.data_type_code  = data_code_ff;
   assign cfg.probe_type_code = probe_code_ff;

endmodule

>>> sv/trd_parse.sv
// record state and per-word header check of the deframer
// depends on trd_pkg and assert_macros.svh
`include "assert_macros.svh"
module trd_parse (
   input  logic                clock,
   input  logic                reset,
   input  trd_pkg::cfg_type    cfg,
   input  trd_pkg::item_type   item,
   input  logic                advance,
   output trd_pkg::result_type res,
   output logic                res_emit
);

   logic [trd_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [trd_pkg::LEN_W-1:0] len_ff, len_in, eff_len;
   logic [7:0]                type_ff, type_in, eff_type;
   logic                      bad_ff, bad_in, eff_bad;
   logic [trd_pkg::CNT_W-1:0] count;
   logic [trd_pkg::CNT_W-1:0] expect_cnt;
   logic                      hdr_past;
   logic                      fwd;
   trd_pkg::status_type       st;

   always_comb begin
      // fields restart at the first word of a record
      eff_len  = (pos_ff == '0) ? '0 : len_ff;
      eff_type = (pos_ff == '0) ? '0 : type_ff;
      eff_bad  = (pos_ff == '0) ? 1'b0 : bad_ff;
      len_in   = eff_len;
      type_in  = eff_type;
      bad_in   = eff_bad;

      hdr_past = item.is_datagram ? (pos_ff != '0)
                                  : (pos_ff >= trd_pkg::POS_W'(trd_pkg::HEADER_BYTES));
      fwd      = hdr_past && (eff_type == cfg.data_type_code);

      if (!hdr_past) begin
         if (item.is_datagram) begin
            type_in = item.data_byte;
         end else begin
            case (pos_ff[2:0])
               trd_pkg::HDR_POS_S: begin
                  if (item.data_byte != trd_pkg::MAGIC_S) bad_in = 1'b1;
               end
               trd_pkg::HDR_POS_T: begin
                  if (item.data_byte != trd_pkg::MAGIC_T) bad_in = 1'b1;
               end
               trd_pkg::HDR_POS_F: begin
                  if (item.data_byte != trd_pkg::MAGIC_F) bad_in = 1'b1;
               end
               trd_pkg::HDR_POS_VER: begin
                  if (item.data_byte != trd_pkg::HDR_VERSION) bad_in = 1'b1;
               end
               trd_pkg::HDR_POS_LEN_HI: begin
                  len_in = {item.data_byte, eff_len[7:0]};
               end
               trd_pkg::HDR_POS_LEN_LO: begin
                  len_in = {eff_len[15:8], item.data_byte};
               end
               trd_pkg::HDR_POS_TYPE: begin
                  type_in = item.data_byte;
               end
               default: begin
                  if (item.data_byte != trd_pkg::HDR_PAD) bad_in = 1'b1;
               end
            endcase
         end
      end

      count      = {1'b0, pos_ff} + trd_pkg::CNT_W'(1);
      expect_cnt = trd_pkg::CNT_W'(trd_pkg::HEADER_BYTES) + {2'b00, len_in};

      if (item.end_of_record) begin
         pos_in = '0;
      end else if (pos_ff == trd_pkg::POS_MAX) begin
         pos_in = trd_pkg::POS_MAX;
      end else begin
         pos_in = count[trd_pkg::POS_W-1:0];
      end

      st = trd_pkg::STATUS_OK;
      if (item.end_of_record && !item.is_datagram) begin
         if (count < trd_pkg::CNT_W'(trd_pkg::HEADER_BYTES)) begin
            st = trd_pkg::STATUS_TOO_SHORT;
         end else if (bad_in) begin
            st = trd_pkg::STATUS_BAD_HEADER;
         end else if (count != expect_cnt) begin
            st = trd_pkg::STATUS_LEN_MISM;
         end
      end

      res.payload_valid     = fwd;
      res.forward_byte      = fwd ? item.data_byte : 8'd0;
      res.record_done       = item.end_of_record;
      res.status            = st;
      res.packet_type       = item.end_of_record ? type_in : 8'd0;
      res.send_probe_reply  = item.end_of_record && (st == trd_pkg::STATUS_OK)
                              && (type_in == cfg.probe_type_code);
      res.reply_on_datagram = res.send_probe_reply && item.is_datagram;
      res_emit              = fwd || item.end_of_record;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         len_ff  <= '0;
         type_ff <= '0;
         bad_ff  <= 1'b0;
      end else if (advance) begin
         pos_ff  <= pos_in;
         len_ff  <= len_in;
         type_ff <= type_in;
         bad_ff  <= bad_in;
      end
   end

   `ASSERT_AT(a_last_restarts, clock, reset,
      (advance && item.end_of_record) |=> (pos_ff == '0))
   `ASSERT_AT(a_pos_saturates, clock, reset,
      (advance && !item.end_of_record && pos_ff == trd_pkg::POS_MAX) |=> (pos_ff == trd_pkg::POS_MAX))
   `ASSERT_AT(a_pos_holds, clock, reset,
      !advance |=> $stable(pos_ff))

endmodule
